[sv/fsp_pkg.sv]
// Package with the shared constants, types and codes of the frame sequence player.
`timescale 1ns / 1ps

package fsp_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int ADDR_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 16;
  localparam int TOTAL_W     = 7;
  localparam int OP_W        = 3;
  localparam int INDEX_W     = 8;
  localparam int FRAME_OUT_W = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK,
    OP_PLAY,
    OP_STOP,
    OP_PAUSE,
    OP_RESUME,
    OP_SEEK_FRAME,
    OP_SEEK_TIME,
    OP_WRITE_DUR
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOPING,
    CFG_CLIP_SPEED,
    CFG_PLAYER_SPEED,
    CFG_FRAME_TOTAL
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic apply_op;
    logic tick_start;
    logic tick_mul;
    logic tick_sum;
    logic tick_upd;
    logic walk_init;
    logic walk_rd;
    logic walk_acc;
    logic walk_finish;
    logic out_load;
  } fsp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic tick_ok;
    logic seek_ok;
    logic walk_end;
    logic walk_hit;
    logic out_free;
  } fsp_sts_t;

endpackage

[sv/fsp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/fsp_ctrl.sv]
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module fsp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fsp_pkg::fsp_sts_t sts,
  output fsp_pkg::fsp_cmd_t cmd
);

  import fsp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_TICK: begin
            if (sts.tick_ok) begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_MUL;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_SEEK_FRAME, OP_SEEK_TIME: begin
            if (sts.seek_ok) begin
              cmd.walk_init = 1'b1;
              state_nxt     = ST_WALK_RD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            cmd.apply_op = 1'b1;
            state_nxt    = ST_DONE;
          end
        endcase
      end
      ST_MUL: begin
        cmd.tick_mul = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.tick_sum = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.tick_upd = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_WALK_RD: begin
        if (sts.walk_end) begin
          cmd.walk_finish = 1'b1;
          state_nxt       = ST_DONE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_WALK_ACC;
        end
      end
      ST_WALK_ACC: begin
        cmd.walk_acc = 1'b1;
        state_nxt    = sts.walk_hit ? ST_DONE : ST_WALK_RD;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/fsp_dp.sv]
// Datapath of the frame sequence player: registers, duration table, arithmetic and result register.
`timescale 1ns / 1ps

module fsp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fsp_pkg::fsp_cmd_t                   cmd,
  output fsp_pkg::fsp_sts_t                   sts,
  input  logic [fsp_pkg::OP_W-1:0]            in_op,
  input  logic [fsp_pkg::TIME_W-1:0]          in_value,
  input  logic [fsp_pkg::INDEX_W-1:0]         in_index,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fsp_pkg::FRAME_OUT_W-1:0]     out_frame_index,
  output logic [fsp_pkg::TIME_W-1:0]          out_elapsed,
  output logic                                out_running,
  output logic                                out_held,
  output logic                                out_frame_valid,
  output logic                                out_frame_changed,
  output logic                                out_completed,
  input  logic                                cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import fsp_pkg::*;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // Configuration registers.
  logic                 looping_r;
  logic [SPEED_W-1:0]   clip_speed_r;
  logic [SPEED_W-1:0]   player_speed_r;
  logic [TOTAL_W-1:0]   frame_total_r;

  // Captured transaction.
  op_t                  op_r;
  logic [TIME_W-1:0]    value_r;
  logic [INDEX_W-1:0]   index_r;
  logic                 restart_r;

  // Player state.
  logic [ADDR_W-1:0]    cf_r, cf_nxt;
  logic [TIME_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]    timer_r, timer_nxt;
  logic                 playing_r, playing_nxt;
  logic                 paused_r, paused_nxt;
  logic                 started_r, started_nxt;
  logic                 changed_r, changed_nxt;
  logic                 done_r, done_nxt;

  // Tick arithmetic and table walk.
  logic [2*SPEED_W-1:0] sp_r;
  logic [TIME_W+2*SPEED_W-1:0] prod_r;
  logic [TIME_W-1:0]    el_sum_r;
  logic [TIME_W-1:0]    tm_sum_r;
  logic [CNT_W-1:0]     walk_cnt_r, walk_cnt_nxt;
  logic [TIME_W-1:0]    acc_r, acc_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic [TIME_W-1:0]      out_elapsed_r;
  logic                   out_running_r;
  logic                   out_held_r;
  logic                   out_fvalid_r;
  logic                   out_changed_r;
  logic                   out_completed_r;

  logic [CNT_W-1:0]     n;
  logic [TIME_W-1:0]    dur;
  logic [TIME_W-1:0]    step;
  logic [TIME_W:0]      walk_sum;
  logic                 walk_hit;
  logic                 dur_we;
  logic                 dur_re;
  logic [ADDR_W-1:0]    dur_raddr;
  logic [CNT_W-1:0]     next_frame;

  assign n = (32'(frame_total_r) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(frame_total_r);

  assign dur_we    = cmd.apply_op && (op_r == OP_WRITE_DUR) && (32'(index_r) < MAX_FRAMES);
  assign dur_re    = cmd.tick_start || cmd.walk_rd;
  assign dur_raddr = cmd.tick_start ? cf_r : walk_cnt_r[ADDR_W-1:0];

  fsp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk     (clk),
    .wr_en   (dur_we),
    .wr_addr (ADDR_W'(index_r)),
    .wr_data (value_r),
    .rd_en   (dur_re),
    .rd_addr (dur_raddr),
    .rd_data (dur)
  );

  assign step = (|prod_r[TIME_W+2*SPEED_W-1:TIME_W+SPEED_W]) ? '1
                : prod_r[TIME_W+SPEED_W-1:SPEED_W];

  assign walk_sum   = {1'b0, acc_r} + {1'b0, dur};
  assign walk_hit   = (op_r == OP_SEEK_TIME) && (walk_sum > {1'b0, value_r});
  assign next_frame = CNT_W'(cf_r) + CNT_W'(1);

  assign sts.op       = op_r;
  assign sts.tick_ok  = playing_r && !paused_r && started_r && (n != '0);
  assign sts.seek_ok  = started_r && ((op_r == OP_SEEK_FRAME) ? (32'(index_r) < 32'(n))
                                                             : (n != '0));
  assign sts.walk_end = (op_r == OP_SEEK_FRAME) ? (walk_cnt_r == CNT_W'(index_r))
                                                : (walk_cnt_r == n);
  assign sts.walk_hit = walk_hit;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    cf_nxt       = cf_r;
    elapsed_nxt  = elapsed_r;
    timer_nxt    = timer_r;
    playing_nxt  = playing_r;
    paused_nxt   = paused_r;
    started_nxt  = started_r;
    changed_nxt  = changed_r;
    done_nxt     = done_r;
    walk_cnt_nxt = walk_cnt_r;
    acc_nxt      = acc_r;

    if (cmd.load_item) begin
      changed_nxt = 1'b0;
      done_nxt    = 1'b0;
    end

    if (cmd.apply_op) begin
      case (op_r)
        OP_PLAY: begin
          if (!(playing_r && !restart_r)) begin
            started_nxt = 1'b1;
            cf_nxt      = '0;
            elapsed_nxt = '0;
            timer_nxt   = '0;
            playing_nxt = 1'b1;
            paused_nxt  = 1'b0;
          end
        end
        OP_STOP: begin
          playing_nxt = 1'b0;
          cf_nxt      = '0;
          elapsed_nxt = '0;
          timer_nxt   = '0;
        end
        OP_PAUSE:  paused_nxt = 1'b1;
        OP_RESUME: paused_nxt = 1'b0;
        default: ;
      endcase
    end

    if (cmd.tick_upd) begin
      elapsed_nxt = el_sum_r;
      timer_nxt   = tm_sum_r;
      if (tm_sum_r >= dur) begin
        timer_nxt = tm_sum_r - dur;
        if (next_frame >= n) begin
          if (looping_r) begin
            cf_nxt      = '0;
            elapsed_nxt = '0;
            changed_nxt = (cf_r != '0);
          end else begin
            cf_nxt      = ADDR_W'(n - CNT_W'(1));
            playing_nxt = 1'b0;
            done_nxt    = 1'b1;
            changed_nxt = (cf_r != ADDR_W'(n - CNT_W'(1)));
          end
        end else begin
          cf_nxt      = ADDR_W'(next_frame);
          changed_nxt = 1'b1;
        end
      end
    end

    if (cmd.walk_init) begin
      walk_cnt_nxt = '0;
      acc_nxt      = '0;
    end

    if (cmd.walk_acc) begin
      if (walk_hit) begin
        cf_nxt      = walk_cnt_r[ADDR_W-1:0];
        timer_nxt   = value_r - acc_r;
        elapsed_nxt = value_r;
      end else begin
        acc_nxt      = walk_sum[TIME_W] ? '1 : walk_sum[TIME_W-1:0];
        walk_cnt_nxt = walk_cnt_r + CNT_W'(1);
      end
    end

    if (cmd.walk_finish) begin
      timer_nxt = '0;
      if (op_r == OP_SEEK_FRAME) begin
        cf_nxt      = ADDR_W'(index_r);
        elapsed_nxt = acc_r;
      end else begin
        cf_nxt      = '0;
        elapsed_nxt = value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looping_r      <= 1'b1;
      clip_speed_r   <= SPEED_W'(256);
      player_speed_r <= SPEED_W'(256);
      frame_total_r  <= '0;
      cf_r           <= '0;
      elapsed_r      <= '0;
      timer_r        <= '0;
      playing_r      <= 1'b0;
      paused_r       <= 1'b0;
      started_r      <= 1'b0;
      changed_r      <= 1'b0;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_LOOPING:      looping_r      <= cfg_wdata[0];
          CFG_CLIP_SPEED:   clip_speed_r   <= cfg_wdata;
          CFG_PLAYER_SPEED: player_speed_r <= cfg_wdata;
          CFG_FRAME_TOTAL:  frame_total_r  <= cfg_wdata[TOTAL_W-1:0];
          default: ;
        endcase
      end
      cf_r      <= cf_nxt;
      elapsed_r <= elapsed_nxt;
      timer_r   <= timer_nxt;
      playing_r <= playing_nxt;
      paused_r  <= paused_nxt;
      started_r <= started_nxt;
      changed_r <= changed_nxt;
      done_r    <= done_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r      <= op_t'(in_op);
      value_r   <= in_value;
      index_r   <= in_index;
      restart_r <= in_restart;
    end
    if (cmd.tick_start) begin
      sp_r <= (2*SPEED_W)'(player_speed_r) * (2*SPEED_W)'(clip_speed_r);
    end
    if (cmd.tick_mul) begin
      prod_r <= (TIME_W+2*SPEED_W)'(value_r) * (TIME_W+2*SPEED_W)'(sp_r);
    end
    if (cmd.tick_sum) begin
      el_sum_r <= sat_add(elapsed_r, step);
      tm_sum_r <= sat_add(timer_r, step);
    end
    walk_cnt_r <= walk_cnt_nxt;
    acc_r      <= acc_nxt;
    if (cmd.out_load) begin
      out_frame_r     <= FRAME_OUT_W'(cf_r);
      out_elapsed_r   <= elapsed_r;
      out_running_r   <= playing_r;
      out_held_r      <= paused_r;
      out_fvalid_r    <= started_r && (n != '0);
      out_changed_r   <= changed_r;
      out_completed_r <= done_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_index   = out_frame_r;
  assign out_elapsed       = out_elapsed_r;
  assign out_running       = out_running_r;
  assign out_held          = out_held_r;
  assign out_frame_valid   = out_fvalid_r;
  assign out_frame_changed = out_changed_r;
  assign out_completed     = out_completed_r;

endmodule

[sv/frame_sequence_player.sv]
// Top level of the frame sequence player: controller plus datapath.
//
//   Channel   Direction  Handshake             Contents
//   in_*      input      in_valid / in_stall   op, value, index, restart
//   out_*     output     out_valid / out_stall frame, elapsed time and status flags
//   cfg_*     input      cfg_we                looping, speeds, frame total
//
// Play, stop, pause, resume, duration writes and ignored ticks or seeks pass
// through the execute and done states only; a tick that plays also passes through
// the duration read, the two registered multiplies and the add stage.
// A seek reads one duration table entry at a time, since the table has a single
// registered read port, and a time seek stops at the entry where it finds its frame.
// Reset clears the player state and loads the register defaults; the duration
// table is not cleared. A stalled result waits in the output register while the
// next transaction is accepted and processed.
`timescale 1ns / 1ps

module frame_sequence_player (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fsp_pkg::OP_W-1:0]         in_op,
  input  logic [fsp_pkg::TIME_W-1:0]       in_value,
  input  logic [fsp_pkg::INDEX_W-1:0]      in_index,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fsp_pkg::FRAME_OUT_W-1:0]  out_frame_index,
  output logic [fsp_pkg::TIME_W-1:0]       out_elapsed,
  output logic                             out_running,
  output logic                             out_held,
  output logic                             out_frame_valid,
  output logic                             out_frame_changed,
  output logic                             out_completed,
  input  logic                             cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import fsp_pkg::*;

  fsp_cmd_t cmd;
  fsp_sts_t sts;

  fsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_index          (in_index),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_index   (out_frame_index),
    .out_elapsed       (out_elapsed),
    .out_running       (out_running),
    .out_held          (out_held),
    .out_frame_valid   (out_frame_valid),
    .out_frame_changed (out_frame_changed),
    .out_completed     (out_completed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

endmodule

[sv/fsp_checker.sv]
// Port-level assertions for the frame sequence player and their bind to the top level.
`timescale 1ns / 1ps

module fsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [fsp_pkg::FRAME_OUT_W-1:0]  out_frame_index,
  input logic [fsp_pkg::TIME_W-1:0]       out_elapsed,
  input logic                             out_running,
  input logic                             out_frame_valid,
  input logic                             out_frame_changed,
  input logic                             out_completed
);

  // A stalled result stays valid and keeps its frame and time.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_index) && $stable(out_elapsed))
    else $error("stalled result changed");

  // After a transaction is accepted, the block stalls its input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // Completion always stops playback.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_completed |-> !out_running && out_frame_valid)
    else $error("completed result still running");

  // An ordinary frame advance happens only during playback of a valid sequence.
  a_advance_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_changed && !out_completed |-> out_running && out_frame_valid)
    else $error("frame advanced while not running");

endmodule

bind frame_sequence_player fsp_checker u_fsp_checker (.*);
